// ----- rtl/wmm_pkg.sv -----
// shared types, sizes and codes for the winograd matrix multiplier
// no dependencies; imported by wmm_mac and winograd_matrix_multiply
`timescale 1ns / 1ps

package wmm_pkg;

  localparam int MAX_DIM    = 8;
  localparam int ELEM_WIDTH = 16;
  localparam int IDX_W      = $clog2(MAX_DIM);
  localparam int DIM_W      = 4;
  localparam int ADDR_W     = 2 * IDX_W;
  localparam int DEPTH      = MAX_DIM * MAX_DIM;
  localparam int OPND_W     = ELEM_WIDTH + 1;
  localparam int PROD_W     = 2 * OPND_W;
  localparam int FACT_W     = 34;
  localparam int ACC_W      = 40;

  typedef enum logic [1:0] {
    OP_WR_A    = 2'd0,
    OP_WR_B    = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_ROWS_A    = 2'd0,
    CFG_INNER_DIM = 2'd1,
    CFG_COLS_B    = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_RF  = 2'd0,
    KIND_CF  = 2'd1,
    KIND_ENT = 2'd2,
    KIND_ODD = 2'd3
  } kind_t;

  typedef struct packed {
    op_t                op;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [15:0] value;
  } in_t;

  typedef struct packed {
    logic [2:0]         out_row;
    logic [2:0]         out_col;
    logic signed [39:0] product;
    logic               last;
  } out_t;

  // control that travels with each term through the pipeline
  typedef struct packed {
    kind_t            kind;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             first;
    logic             last;
    logic             sub_f;
    logic             fin;
  } tag_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             fin;
    logic [ACC_W-1:0] sum;
  } res_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (d > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = d;
    end
    return r;
  endfunction

endpackage

// ----- rtl/wmm_mac.sv -----
// shared multiply-accumulate unit: operand forming, one multiplier, accumulator
// holds the row and column factor registers; depends on wmm_pkg
`timescale 1ns / 1ps

module wmm_mac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              s1_v,
  input  wmm_pkg::tag_t                     s1_tag,
  input  logic [wmm_pkg::ELEM_WIDTH-1:0]    rd_a0,
  input  logic [wmm_pkg::ELEM_WIDTH-1:0]    rd_a1,
  input  logic [wmm_pkg::ELEM_WIDTH-1:0]    rd_b0,
  input  logic [wmm_pkg::ELEM_WIDTH-1:0]    rd_b1,
  output logic                              busy,
  output wmm_pkg::res_t                     res
);
  import wmm_pkg::*;

  logic signed [OPND_W-1:0] a0x, a1x, b0x, b1x;
  logic signed [OPND_W-1:0] opx, opy;
  logic signed [OPND_W-1:0] opx_r, opy_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     s2_v_r, s3_v_r;
  tag_t                     s2_tag_r, s3_tag_r;
  logic [ACC_W-1:0]         acc_r;
  logic [ACC_W-1:0]         acc_in, acc_nxt, base, prod_x, rf_x, cf_x;
  logic [FACT_W-1:0]        rf_r [MAX_DIM];
  logic [FACT_W-1:0]        cf_r [MAX_DIM];
  logic [FACT_W-1:0]        rf_sel, cf_sel;

  assign a0x = $signed({rd_a0[ELEM_WIDTH-1], rd_a0});
  assign a1x = $signed({rd_a1[ELEM_WIDTH-1], rd_a1});
  assign b0x = $signed({rd_b0[ELEM_WIDTH-1], rd_b0});
  assign b1x = $signed({rd_b1[ELEM_WIDTH-1], rd_b1});

  // operand pair for this term
  always_comb begin
    case (s1_tag.kind)
      KIND_RF: begin
        opx = a0x;
        opy = a1x;
      end
      KIND_CF: begin
        opx = b0x;
        opy = b1x;
      end
      KIND_ENT: begin
        opx = a1x + b0x;
        opy = a0x + b1x;
      end
      KIND_ODD: begin
        opx = a0x;
        opy = b0x;
      end
      default: begin
        opx = a0x;
        opy = a1x;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_tag_r <= s1_tag;
      opx_r    <= opx;
      opy_r    <= opy;
      s3_tag_r <= s2_tag_r;
      prod_r   <= opx_r * opy_r;
    end
  end

  // accumulate, from minus both factors on a result entry (zero if inner dim < 2)
  assign rf_sel = rf_r[s3_tag_r.row];
  assign cf_sel = cf_r[s3_tag_r.col];
  assign rf_x   = {{(ACC_W-FACT_W){rf_sel[FACT_W-1]}}, rf_sel};
  assign cf_x   = {{(ACC_W-FACT_W){cf_sel[FACT_W-1]}}, cf_sel};
  assign prod_x = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign base   = s3_tag_r.sub_f ? ('0 - rf_x - cf_x) : '0;
  assign acc_in = s3_tag_r.first ? base : acc_r;
  assign acc_nxt = acc_in + prod_x;

  always_ff @(posedge clk) begin
    if (adv && s3_v_r) begin
      acc_r <= acc_nxt;
      if (s3_tag_r.last && s3_tag_r.kind == KIND_RF) begin
        rf_r[s3_tag_r.row] <= acc_nxt[FACT_W-1:0];
      end
      if (s3_tag_r.last && s3_tag_r.kind == KIND_CF) begin
        cf_r[s3_tag_r.col] <= acc_nxt[FACT_W-1:0];
      end
    end
  end

  assign busy      = s2_v_r || s3_v_r;
  assign res.valid = s3_v_r && s3_tag_r.last &&
                     (s3_tag_r.kind == KIND_ENT || s3_tag_r.kind == KIND_ODD);
  assign res.row   = s3_tag_r.row;
  assign res.col   = s3_tag_r.col;
  assign res.fin   = s3_tag_r.fin;
  assign res.sum   = acc_nxt;

endmodule

// ----- rtl/winograd_matrix_multiply.sv -----
// winograd inner-product matrix multiplier, top level
// sequencer, element memories and result register; depends on wmm_pkg, wmm_mac
// usage:
//   in channel: one request per item. op write-a / write-b stores one element
//   at (row, col). op compute runs the whole product.
//   out channel: one request per entry of the result, row-major, last set on
//   the final entry. cfg channel: rows_a, inner_dim, cols_b, always ready;
//   a dimension of 0 acts as 1, above 8 acts as 8.
//   every term of a compute request goes through the one shared 17x17
//   multiplier, one term per cycle while the out channel does not stall,
//   behind a read / multiply / accumulate pipeline.
//   in_ready is high only while no compute is in flight.
//   a stalled out channel freezes the whole pipeline; nothing is dropped,
//   and one finished entry waits in the output register.
//   reset sets the dimensions to 8 and empties the pipeline; element
//   memories and factors hold nothing until written.
`timescale 1ns / 1ps

module winograd_matrix_multiply (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  wmm_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output wmm_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [3:0]    cfg_data
);
  import wmm_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_RF    = 5'b00010,
    ST_CF    = 5'b00100,
    ST_ENT   = 5'b01000,
    ST_DRAIN = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [DIM_W-1:0]     rows_a_r, inner_dim_r, cols_b_r;
  logic [DIM_W-1:0]     nr, nn, nc, half, nterm;
  logic [IDX_W-1:0]     i_r, j_r, k_r, i_nxt, j_nxt, k_nxt;
  logic [IDX_W-1:0]     two_k, two_k1;
  logic [ADDR_W-1:0]    addr_a0, addr_a1, addr_b0, addr_b1, wr_addr;
  logic                 adv, issue, grp_end, i_end, j_end;
  logic                 in_acc, wr_a, wr_b;
  kind_t                cur_kind;
  tag_t                 cur_tag, s1_tag_r;
  logic                 s1_v_r;
  logic [ELEM_WIDTH-1:0] mem_a [DEPTH];
  logic [ELEM_WIDTH-1:0] mem_b [DEPTH];
  logic [ELEM_WIDTH-1:0] rd_a0_r, rd_a1_r, rd_b0_r, rd_b1_r;
  logic                 mac_busy;
  res_t                 res;
  logic                 out_v_r;
  out_t                 out_r;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= DIM_W'(8);
      inner_dim_r <= DIM_W'(8);
      cols_b_r    <= DIM_W'(8);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ROWS_A:    rows_a_r    <= cfg_data;
        CFG_INNER_DIM: inner_dim_r <= cfg_data;
        CFG_COLS_B:    cols_b_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign nr    = clamp_dim(rows_a_r);
  assign nn    = clamp_dim(inner_dim_r);
  assign nc    = clamp_dim(cols_b_r);
  assign half  = nn >> 1;
  assign nterm = half + {{(DIM_W-1){1'b0}}, nn[0]};

  // sequencer
  assign adv      = !out_v_r || out_ready;
  assign issue    = (state_r == ST_RF) || (state_r == ST_CF) || (state_r == ST_ENT);
  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign i_end    = DIM_W'(i_r) == nr - DIM_W'(1);
  assign j_end    = DIM_W'(j_r) == nc - DIM_W'(1);
  assign grp_end  = (state_r == ST_ENT) ? (DIM_W'(k_r) == nterm - DIM_W'(1))
                                        : (DIM_W'(k_r) == half - DIM_W'(1));

  always_comb begin
    if (state_r == ST_RF) begin
      cur_kind = KIND_RF;
    end else if (state_r == ST_CF) begin
      cur_kind = KIND_CF;
    end else if (DIM_W'(k_r) == half) begin
      cur_kind = KIND_ODD;
    end else begin
      cur_kind = KIND_ENT;
    end
  end

  assign cur_tag.kind  = cur_kind;
  assign cur_tag.row   = i_r;
  assign cur_tag.col   = j_r;
  assign cur_tag.first = (k_r == '0);
  assign cur_tag.last  = grp_end;
  assign cur_tag.sub_f = (state_r == ST_ENT) && (half != '0);
  assign cur_tag.fin   = i_end && j_end;

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_data.op == OP_COMPUTE) begin
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
          state_nxt = (half != '0) ? ST_RF : ST_ENT;
        end
      end
      ST_RF: begin
        if (adv) begin
          if (grp_end) begin
            k_nxt = '0;
            if (i_end) begin
              i_nxt     = '0;
              state_nxt = ST_CF;
            end else begin
              i_nxt = i_r + IDX_W'(1);
            end
          end else begin
            k_nxt = k_r + IDX_W'(1);
          end
        end
      end
      ST_CF: begin
        if (adv) begin
          if (grp_end) begin
            k_nxt = '0;
            if (j_end) begin
              j_nxt     = '0;
              state_nxt = ST_ENT;
            end else begin
              j_nxt = j_r + IDX_W'(1);
            end
          end else begin
            k_nxt = k_r + IDX_W'(1);
          end
        end
      end
      ST_ENT: begin
        if (adv) begin
          if (grp_end) begin
            k_nxt = '0;
            if (j_end) begin
              j_nxt = '0;
              if (i_end) begin
                i_nxt     = '0;
                state_nxt = ST_DRAIN;
              end else begin
                i_nxt = i_r + IDX_W'(1);
              end
            end else begin
              j_nxt = j_r + IDX_W'(1);
            end
          end else begin
            k_nxt = k_r + IDX_W'(1);
          end
        end
      end
      ST_DRAIN: begin
        if (!s1_v_r && !mac_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  // element memories, two registered read ports each
  assign two_k   = {k_r[IDX_W-2:0], 1'b0};
  assign two_k1  = {k_r[IDX_W-2:0], 1'b1};
  assign addr_a0 = {i_r, two_k};
  assign addr_a1 = {i_r, two_k1};
  assign addr_b0 = {two_k, j_r};
  assign addr_b1 = {two_k1, j_r};
  assign wr_addr = {in_data.row, in_data.col};
  assign wr_a    = in_acc && (in_data.op == OP_WR_A);
  assign wr_b    = in_acc && (in_data.op == OP_WR_B);

  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[wr_addr] <= in_data.value[ELEM_WIDTH-1:0];
    end
    if (adv) begin
      rd_a0_r <= mem_a[addr_a0];
      rd_a1_r <= mem_a[addr_a1];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[wr_addr] <= in_data.value[ELEM_WIDTH-1:0];
    end
    if (adv) begin
      rd_b0_r <= mem_b[addr_b0];
      rd_b1_r <= mem_b[addr_b1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tag_r <= cur_tag;
    end
  end

  wmm_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .s1_v   (s1_v_r),
    .s1_tag (s1_tag_r),
    .rd_a0  (rd_a0_r),
    .rd_a1  (rd_a1_r),
    .rd_b0  (rd_b0_r),
    .rd_b1  (rd_b1_r),
    .busy   (mac_busy),
    .res    (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv && res.valid) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.valid) begin
      out_r.out_row <= 3'(res.row);
      out_r.out_col <= 3'(res.col);
      out_r.product <= $signed(res.sum);
      out_r.last    <= res.fin;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // checks
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !s1_v_r && !mac_busy)
    else $error("pipeline busy while accepting requests");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready && issue) |=>
      $stable(i_r) && $stable(j_r) && $stable(k_r) && $stable(state_r))
    else $error("term sequencer moved during output stall");

  a_res_phase: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (state_r == ST_ENT || state_r == ST_DRAIN))
    else $error("result entry outside the product phase");

endmodule

// ----- test/winograd_matrix_multiply_test.sv -----
// testbench for winograd_matrix_multiply: element loads, compute requests and
// dimension settings, each result entry checked against a built-in product predictor
// depends on wmm_pkg and winograd_matrix_multiply
`timescale 1ns / 1ps

module winograd_matrix_multiply_test;
  import wmm_pkg::*;

  // rows_a, inner_dim, cols_b per nibble for the first seven segments
  localparam logic [11:0] FIXED_DIMS [7] = '{12'h111, 12'h000, 12'hfff, 12'h352,
                                             12'h818, 12'h970, 12'h283};
  localparam int SEGMENTS = 10;
  localparam int SEG_ITEMS = 5;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_t        in_data;
  logic       out_valid;
  logic       out_ready;
  out_t       out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [3:0] cfg_data;

  in_t                pending_q[$];
  out_t               entry_q[$];
  logic signed [15:0] mat_a [MAX_DIM][MAX_DIM];
  logic signed [15:0] mat_b [MAX_DIM][MAX_DIM];
  logic [3:0]         dim_rows;
  logic [3:0]         dim_inner;
  logic [3:0]         dim_cols;
  logic               in_fire = 1'b0;
  int                 send_idle_pct;
  int                 sink_idle_pct;
  int                 faults = 0;

  winograd_matrix_multiply dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int eff_dim(input logic [3:0] d);
    if (d == 4'd0) begin
      return 1;
    end
    if (d > 4'(MAX_DIM)) begin
      return MAX_DIM;
    end
    return int'(d);
  endfunction

  function automatic in_t make_req(input op_t op, input int r, input int c,
                                   input logic [15:0] v);
    in_t q;
    q.op = op;
    q.row = 3'(r);
    q.col = 3'(c);
    q.value = v;
    return q;
  endfunction

  function automatic logic [15:0] pick_value();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // row and column factors first, then every entry in row-major order
  task automatic predict_product();
    int     nr, n, nc, half, i, j, k;
    longint rf [MAX_DIM];
    longint cf [MAX_DIM];
    longint s;
    out_t   e;
    nr = eff_dim(dim_rows);
    n = eff_dim(dim_inner);
    nc = eff_dim(dim_cols);
    half = n / 2;
    for (i = 0; i < nr; i++) begin
      s = 0;
      for (k = 0; k < half; k++) begin
        s += longint'(mat_a[i][2*k]) * longint'(mat_a[i][2*k+1]);
      end
      rf[i] = s;
    end
    for (j = 0; j < nc; j++) begin
      s = 0;
      for (k = 0; k < half; k++) begin
        s += longint'(mat_b[2*k][j]) * longint'(mat_b[2*k+1][j]);
      end
      cf[j] = s;
    end
    for (i = 0; i < nr; i++) begin
      for (j = 0; j < nc; j++) begin
        s = -rf[i] - cf[j];
        for (k = 0; k < half; k++) begin
          s += (longint'(mat_a[i][2*k+1]) + longint'(mat_b[2*k][j])) *
               (longint'(mat_a[i][2*k]) + longint'(mat_b[2*k+1][j]));
        end
        // odd inner dimension: last column of a times last row of b
        if (n % 2 == 1) begin
          s += longint'(mat_a[i][n-1]) * longint'(mat_b[n-1][j]);
        end
        e.out_row = 3'(i);
        e.out_col = 3'(j);
        e.product = s[39:0];
        e.last = (i == nr - 1) && (j == nc - 1);
        entry_q.push_back(e);
      end
    end
  endtask

  task automatic apply_request(input in_t req);
    case (req.op)
      OP_WR_A:    mat_a[req.row][req.col] = req.value;
      OP_WR_B:    mat_b[req.row][req.col] = req.value;
      OP_COMPUTE: predict_product();
      default:    ;
    endcase
  endtask

  task automatic flag_entry(input string why, input out_t want, input out_t got);
    faults++;
    if (faults <= 10) begin
      $display("%s: want row %0d col %0d product %0d last %0d", why,
               want.out_row, want.out_col, want.product, want.last);
      $display("  got row %0d col %0d product %0d last %0d",
               got.out_row, got.out_col, got.product, got.last);
    end
  endtask

  task automatic check_entry(input out_t got);
    out_t want;
    if (entry_q.size() == 0) begin
      flag_entry("unexpected entry", '0, got);
    end else begin
      want = entry_q.pop_front();
      if (got.out_row !== want.out_row || got.out_col !== want.out_col ||
          got.product !== want.product || got.last !== want.last) begin
        flag_entry("entry mismatch", want, got);
      end
    end
  endtask

  // sender and receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_fire) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    in_fire <= in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        apply_request(in_data);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ROWS_A:    dim_rows = cfg_data;
          CFG_INNER_DIM: dim_inner = cfg_data;
          CFG_COLS_B:    dim_cols = cfg_data;
          default:       ;
        endcase
      end
      if (out_valid && out_ready) begin
        check_entry(out_data);
      end
    end
  end

  task automatic wait_idle();
    do @(posedge clk); while (pending_q.size() != 0 || in_valid || entry_q.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [3:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int         seg, k, pick;
    logic [3:0] r_dim, n_dim, c_dim;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    dim_rows = 4'd8;
    dim_inner = 4'd8;
    dim_cols = 4'd8;
    send_idle_pct = 30;
    sink_idle_pct = 67;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // load every element so no compute reads an unwritten one
    for (int r = 0; r < MAX_DIM; r++) begin
      for (int c = 0; c < MAX_DIM; c++) begin
        pending_q.push_back(make_req(OP_WR_A, r, c, pick_value()));
        pending_q.push_back(make_req(OP_WR_B, r, c, pick_value()));
      end
    end

    // most negative row of a and column of b, largest positive corner
    for (k = 0; k < MAX_DIM; k++) begin
      pending_q.push_back(make_req(OP_WR_A, 0, k, 16'h8000));
      pending_q.push_back(make_req(OP_WR_B, k, 0, 16'h8000));
    end
    pending_q.push_back(make_req(OP_WR_A, 7, 0, 16'h7fff));
    pending_q.push_back(make_req(OP_WR_A, 7, 1, 16'h7fff));
    pending_q.push_back(make_req(OP_WR_B, 0, 7, 16'h7fff));
    pending_q.push_back(make_req(OP_WR_B, 1, 7, 16'h7fff));
    // unused op must leave the stores alone
    pending_q.push_back(make_req(OP_NONE, 7, 7, 16'hffff));
    pending_q.push_back(make_req(OP_COMPUTE, 7, 7, 16'hffff));
    wait_idle();

    for (seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == 4) begin
        send_idle_pct = 67;
        sink_idle_pct = 30;
      end
      if (seg == 7) begin
        send_idle_pct = 0;
        sink_idle_pct = 0;
      end
      if (seg < 7) begin
        r_dim = FIXED_DIMS[seg][11:8];
        n_dim = FIXED_DIMS[seg][7:4];
        c_dim = FIXED_DIMS[seg][3:0];
      end else begin
        r_dim = 4'($urandom_range(15));
        n_dim = 4'($urandom_range(15));
        c_dim = 4'($urandom_range(15));
      end
      write_reg(CFG_ROWS_A, r_dim);
      write_reg(CFG_INNER_DIM, n_dim);
      write_reg(CFG_COLS_B, c_dim);

      for (k = 0; k < SEG_ITEMS; k++) begin
        pick = $urandom_range(99);
        if (k == SEG_ITEMS - 1 || (pick >= 4 && pick < 14)) begin
          pending_q.push_back(make_req(OP_COMPUTE, $urandom_range(7),
                                       $urandom_range(7), 16'($urandom)));
        end else if (pick < 4) begin
          pending_q.push_back(make_req(OP_NONE, $urandom_range(7),
                                       $urandom_range(7), 16'($urandom)));
        end else begin
          pending_q.push_back(make_req($urandom_range(1) ? OP_WR_B : OP_WR_A,
                                       $urandom_range(7), $urandom_range(7),
                                       pick_value()));
        end
      end
      wait_idle();
    end

    if (faults == 0) begin
      $display("winograd_matrix_multiply test passed");
    end else begin
      $display("winograd_matrix_multiply test failed");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("winograd_matrix_multiply test failed");
    $finish;
  end

endmodule
